>>> hdl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants for the C-minus token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Token kinds, in result code order.
  typedef enum logic [4:0] {
    K_END, K_ID, K_NUM, K_VOID, K_INT, K_IF, K_ELSE, K_WHILE, K_RETURN,
    K_PLUS, K_MINUS, K_TIMES, K_DIV, K_LT, K_LE, K_GT, K_GE, K_ASN, K_EQ,
    K_NE, K_SEMI, K_COMMA, K_LPAREN, K_RPAREN, K_LBRACK, K_RBRACK,
    K_LBRACE, K_RBRACE, K_ERR
  } kind_e;

  // Fixed-width part of one result item.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] length;
    logic [7:0] bad;
    logic       last;
  } tok_meta_t;

  localparam int META_W   = $bits(tok_meta_t);
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QLVL_W   = $clog2(QDEPTH + 1);

endpackage

>>> hdl/cts_front.sv
// ----------------------------------------------------------------------------
// cts_front
// Scanner state machine: takes one byte, updates scan state, emits 0..2 items.
// ----------------------------------------------------------------------------
module cts_front #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [7:0]             ch_i,
  output logic [1:0]             push_cnt_o,
  output cts_pkg::tok_meta_t     res0_meta_o,
  output logic [OFFSET_BITS-1:0] res0_start_o,
  output cts_pkg::tok_meta_t     res1_meta_o,
  output logic [OFFSET_BITS-1:0] res1_start_o,
  output logic [LINE_BITS-1:0]   line_o
);

  typedef enum logic [9:0] {
    ST_START   = 10'b00_0000_0001,
    ST_ID      = 10'b00_0000_0010,
    ST_NUM     = 10'b00_0000_0100,
    ST_SLASH   = 10'b00_0000_1000,
    ST_COMMENT = 10'b00_0001_0000,
    ST_CSTAR   = 10'b00_0010_0000,
    ST_LESS    = 10'b00_0100_0000,
    ST_GREATER = 10'b00_1000_0000,
    ST_ASSIGN  = 10'b01_0000_0000,
    ST_NOT     = 10'b10_0000_0000
  } stage_e;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

  // Keywords packed first letter in the low byte, zero padded.
  localparam logic [47:0] KW_VOID   = {16'h0, "diov"};
  localparam logic [47:0] KW_INT    = {24'h0, "tni"};
  localparam logic [47:0] KW_IF     = {32'h0, "fi"};
  localparam logic [47:0] KW_ELSE   = {16'h0, "esle"};
  localparam logic [47:0] KW_WHILE  = {8'h0, "elihw"};
  localparam logic [47:0] KW_RETURN = "nruter";

  function automatic cts_pkg::kind_e kw_kind(input logic [47:0] pre, input logic [7:0] len);
    cts_pkg::kind_e k;
    k = cts_pkg::K_ID;
    if (len == 8'd4 && pre == KW_VOID)   k = cts_pkg::K_VOID;
    if (len == 8'd3 && pre == KW_INT)    k = cts_pkg::K_INT;
    if (len == 8'd2 && pre == KW_IF)     k = cts_pkg::K_IF;
    if (len == 8'd4 && pre == KW_ELSE)   k = cts_pkg::K_ELSE;
    if (len == 8'd5 && pre == KW_WHILE)  k = cts_pkg::K_WHILE;
    if (len == 8'd6 && pre == KW_RETURN) k = cts_pkg::K_RETURN;
    return k;
  endfunction

  stage_e                 stage_q, stage_d;
  logic [LINE_BITS-1:0]   line_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic [OFFSET_BITS-1:0] cur_start_q;
  logic [7:0]             cur_len_q;
  logic [5:0][7:0]        prefix_q;

  logic accept;
  logic is_alpha, is_digit, is_ws;

  // start-stage scan of the current byte
  stage_e         ss_stage;
  logic           ss_tok, ss_id, ss_emit, ss_nl;
  cts_pkg::kind_e ss_kind;
  logic [7:0]     ss_len, ss_bad;

  logic                   run_ss, line_inc, len_inc, pre_wr;
  logic                   r0v, r1v;
  cts_pkg::tok_meta_t     r0, r1;
  logic [OFFSET_BITS-1:0] r0_start, r1_start;

  assign accept   = in_valid_i & in_ready_i;
  assign is_alpha = (ch_i >= "a" && ch_i <= "z") || (ch_i >= "A" && ch_i <= "Z");
  assign is_digit = (ch_i >= "0" && ch_i <= "9");
  assign is_ws    = (ch_i == 8'd32) || (ch_i >= 8'd9 && ch_i <= 8'd13);

  always_comb begin
    ss_stage = ST_START;
    ss_tok   = 1'b0;
    ss_id    = 1'b0;
    ss_emit  = 1'b0;
    ss_nl    = 1'b0;
    ss_kind  = cts_pkg::K_END;
    ss_len   = 8'd1;
    ss_bad   = 8'd0;
    if (is_alpha) begin
      ss_stage = ST_ID;
      ss_tok   = 1'b1;
      ss_id    = 1'b1;
    end else if (is_digit) begin
      ss_stage = ST_NUM;
      ss_tok   = 1'b1;
    end else if (is_ws) begin
      ss_nl = (ch_i == 8'd10);
    end else begin
      unique case (ch_i)
        "/": begin ss_stage = ST_SLASH;   ss_tok = 1'b1; end
        "<": begin ss_stage = ST_LESS;    ss_tok = 1'b1; end
        ">": begin ss_stage = ST_GREATER; ss_tok = 1'b1; end
        "=": begin ss_stage = ST_ASSIGN;  ss_tok = 1'b1; end
        "!": begin ss_stage = ST_NOT;     ss_tok = 1'b1; end
        8'd0: begin ss_emit = 1'b1; ss_kind = cts_pkg::K_END; ss_len = 8'd0; end
        "+": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_PLUS;   end
        "-": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_MINUS;  end
        "*": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_TIMES;  end
        ";": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_SEMI;   end
        ",": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_COMMA;  end
        "(": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_LPAREN; end
        ")": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_RPAREN; end
        "[": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_LBRACK; end
        "]": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_RBRACK; end
        "{": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_LBRACE; end
        "}": begin ss_emit = 1'b1; ss_kind = cts_pkg::K_RBRACE; end
        default: begin ss_emit = 1'b1; ss_kind = cts_pkg::K_ERR; ss_bad = ch_i; end
      endcase
    end
  end

  always_comb begin
    stage_d  = stage_q;
    run_ss   = 1'b0;
    line_inc = 1'b0;
    len_inc  = 1'b0;
    pre_wr   = 1'b0;
    r0v      = 1'b0;
    r0       = '{kind: cts_pkg::K_END, length: 8'd1, bad: 8'd0, last: 1'b0};
    r0_start = cur_start_q;
    r1v      = 1'b0;
    r1       = '{kind: cts_pkg::K_END, length: 8'd0, bad: 8'd0, last: 1'b1};
    r1_start = off_q;
    unique case (stage_q)
      ST_ID: begin
        if (is_alpha) begin
          pre_wr  = 1'b1;
          len_inc = 1'b1;
        end else begin
          r0v       = 1'b1;
          r0.kind   = kw_kind(prefix_q, cur_len_q);
          r0.length = cur_len_q;
          run_ss    = 1'b1;
        end
      end
      ST_NUM: begin
        if (is_digit) begin
          len_inc = 1'b1;
        end else begin
          r0v       = 1'b1;
          r0.kind   = cts_pkg::K_NUM;
          r0.length = cur_len_q;
          run_ss    = 1'b1;
        end
      end
      ST_SLASH: begin
        if (ch_i == "*") begin
          stage_d = ST_COMMENT;
        end else begin
          r0v     = 1'b1;
          r0.kind = cts_pkg::K_DIV;
          run_ss  = 1'b1;
        end
      end
      ST_COMMENT: begin
        if (ch_i == "*") begin
          stage_d = ST_CSTAR;
        end else if (ch_i == 8'd10) begin
          line_inc = 1'b1;
        end else if (ch_i == 8'd0) begin
          stage_d = ST_START;
          r1v     = 1'b1;
        end
      end
      ST_CSTAR: begin
        if (ch_i == "/") begin
          stage_d = ST_START;
        end else if (ch_i == 8'd0) begin
          stage_d = ST_START;
          r1v     = 1'b1;
        end else if (ch_i != "*") begin
          stage_d  = ST_COMMENT;
          line_inc = (ch_i == 8'd10);
        end
      end
      ST_LESS, ST_GREATER, ST_ASSIGN, ST_NOT: begin
        r0v = 1'b1;
        if (ch_i == "=") begin
          stage_d   = ST_START;
          r0.length = 8'd2;
          unique case (stage_q)
            ST_LESS:    r0.kind = cts_pkg::K_LE;
            ST_GREATER: r0.kind = cts_pkg::K_GE;
            ST_ASSIGN:  r0.kind = cts_pkg::K_EQ;
            default:    r0.kind = cts_pkg::K_NE;
          endcase
        end else begin
          run_ss = 1'b1;
          unique case (stage_q)
            ST_LESS:    r0.kind = cts_pkg::K_LT;
            ST_GREATER: r0.kind = cts_pkg::K_GT;
            ST_ASSIGN:  r0.kind = cts_pkg::K_ASN;
            default: begin
              r0.kind = cts_pkg::K_ERR;
              r0.bad  = ch_i;
            end
          endcase
        end
      end
      default: run_ss = 1'b1;
    endcase

    if (run_ss) begin
      stage_d   = ss_stage;
      line_inc  = ss_nl;
      r1v       = ss_emit;
      r1.kind   = ss_kind;
      r1.length = ss_len;
      r1.bad    = ss_bad;
    end
    r0.last = ~r1v;
  end

  // compact: a lone result always goes out in slot 0
  always_comb begin
    res0_meta_o  = r0v ? r0 : r1;
    res0_start_o = r0v ? r0_start : r1_start;
    res1_meta_o  = r1;
    res1_start_o = r1_start;
    push_cnt_o   = accept ? ({1'b0, r0v} + {1'b0, r1v}) : 2'd0;
  end

  assign line_o = line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_START;
      line_q      <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      off_q       <= '0;
      cur_start_q <= '0;
      cur_len_q   <= '0;
      prefix_q    <= '0;
    end else if (accept) begin
      stage_q <= stage_d;
      if (off_q != OFF_MAX) off_q <= off_q + 1'b1;
      if (line_inc && line_q != LINE_MAX) line_q <= line_q + 1'b1;
      if (run_ss && ss_tok) begin
        cur_start_q <= off_q;
        cur_len_q   <= 8'd1;
        if (ss_id) prefix_q <= {40'h0, ch_i};
      end else if (len_inc) begin
        if (cur_len_q != 8'd255) cur_len_q <= cur_len_q + 8'd1;
        if (pre_wr && cur_len_q < 8'd6) prefix_q[cur_len_q[2:0]] <= ch_i;
      end
    end
  end

endmodule

>>> hdl/cts_queue.sv
// ----------------------------------------------------------------------------
// cts_queue
// Short result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module cts_queue #(
  parameter int W = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_cnt_i,
  input  logic [W-1:0]               wr0_i,
  input  logic [W-1:0]               wr1_i,
  input  logic                       pop_i,
  output logic                       rd_valid_o,
  output logic [W-1:0]               rd_data_o,
  output logic [cts_pkg::QLVL_W-1:0] level_o,
  output logic                       room_o
);

  logic [W-1:0]               mem_q [cts_pkg::QDEPTH];
  logic [cts_pkg::QPTR_W-1:0] wp_q, rp_q, wp1;
  logic [cts_pkg::QLVL_W-1:0] lvl_q;

  assign wp1        = wp_q + 1'b1;
  assign rd_valid_o = (lvl_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign level_o    = lvl_q;
  // two free slots so that a two-result byte always fits
  assign room_o     = (lvl_q <= cts_pkg::QLVL_W'(cts_pkg::QDEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wp_q] <= wr0_i;
    if (push_cnt_i == 2'd2) mem_q[wp1]  <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      lvl_q <= '0;
    end else begin
      wp_q  <= wp_q + cts_pkg::QPTR_W'(push_cnt_i);
      if (pop_i) rp_q <= rp_q + 1'b1;
      lvl_q <= lvl_q + cts_pkg::QLVL_W'(push_cnt_i) - cts_pkg::QLVL_W'(pop_i);
    end
  end

endmodule

>>> hdl/cts_back.sv
// ----------------------------------------------------------------------------
// cts_back
// Output stage: drains the queue into the result register.
// ----------------------------------------------------------------------------
module cts_back #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  logic [W-1:0] q_data_i,
  output logic         pop_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [W-1:0] out_data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  assign pop_o       = q_valid_i & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= q_data_i;
  end

endmodule

>>> hdl/cminus_token_scanner_unit.sv
// ----------------------------------------------------------------------------
// cminus_token_scanner_unit
// Byte-stream lexical scanner for C-minus source text.
// ----------------------------------------------------------------------------
// Path: each result of an accepted byte is written into the result queue and
//   then into the output register, where it waits for out_ready_i.
// Throughput: one byte per cycle while the queue has room; the queue drains one
//   item per cycle unless the sink stalls, so two-item bytes can fill it.
// Input is taken while the four-entry queue has two free slots.
// Reset: asynchronous, active low; scanner at start, line one, offset zero.
// ----------------------------------------------------------------------------
module cminus_token_scanner_unit #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             ch_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [4:0]             token_kind_o,
  output logic [OFFSET_BITS-1:0] token_start_o,
  output logic [7:0]             token_length_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [7:0]             bad_byte_o,
  output logic                   last_of_run_o
);

  // queue entry: {meta, start offset, line}
  localparam int W = cts_pkg::META_W + OFFSET_BITS + LINE_BITS;

  logic [1:0]                 push_cnt;
  cts_pkg::tok_meta_t         res0_meta, res1_meta, out_meta;
  logic [OFFSET_BITS-1:0]     res0_start, res1_start;
  logic [LINE_BITS-1:0]       line;
  logic [W-1:0]               wr0, wr1, q_data, out_data;
  logic                       q_valid, pop;
  logic [cts_pkg::QLVL_W-1:0] level;

  // Front end: scanner state machine, one byte per accepted item.
  cts_front #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .ch_i        (ch_i),
    .push_cnt_o  (push_cnt),
    .res0_meta_o (res0_meta),
    .res0_start_o(res0_start),
    .res1_meta_o (res1_meta),
    .res1_start_o(res1_start),
    .line_o      (line)
  );

  // Every result of one byte carries the line count as it was before it.
  assign wr0 = {res0_meta, res0_start, line};
  assign wr1 = {res1_meta, res1_start, line};

  // Decoupling queue between scanner and output stage.
  cts_queue #(.W(W)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(push_cnt),
    .wr0_i     (wr0),
    .wr1_i     (wr1),
    .pop_i     (pop),
    .rd_valid_o(q_valid),
    .rd_data_o (q_data),
    .level_o   (level),
    .room_o    (in_ready_o)
  );

  // Back end: registered output, drains one item per cycle unless the sink stalls.
  cts_back #(.W(W)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .pop_o      (pop),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data)
  );

  assign out_meta       = cts_pkg::tok_meta_t'(out_data[W-1 -: cts_pkg::META_W]);
  assign token_kind_o   = out_meta.kind;
  assign token_length_o = out_meta.length;
  assign bad_byte_o     = out_meta.bad;
  assign last_of_run_o  = out_meta.last;
  assign token_start_o  = out_data[LINE_BITS +: OFFSET_BITS];
  assign line_number_o  = out_data[LINE_BITS-1:0];

`ifndef SYNTH
  // results enter the queue only on an accepted byte
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt != 2'd0) |-> (in_valid_i && in_ready_o))
    else $error("results pushed without an accepted byte");

  // the queue never holds more than its depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= cts_pkg::QLVL_W'(cts_pkg::QDEPTH))
    else $error("result queue overflow");

  // an end item has no text and closes its byte's run
  a_end_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o == cts_pkg::K_END) |->
      (token_length_o == 8'd0 && bad_byte_o == 8'd0 && last_of_run_o))
    else $error("malformed end item");
`endif

endmodule

>>> tb/cts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_checker
// Watches both channels of the token scanner. It predicts the token items
// that each accepted source byte gives and compares every item that leaves
// the block with the oldest one still expected.
// ----------------------------------------------------------------------------
module cts_checker #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [7:0]             ch_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [4:0]             token_kind_i,
  input  logic [OFFSET_BITS-1:0] token_start_i,
  input  logic [7:0]             token_length_i,
  input  logic [LINE_BITS-1:0]   line_number_i,
  input  logic [7:0]             bad_byte_i,
  input  logic                   last_of_run_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam logic [7:0] CH_END     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [3:0] {
    SCAN_START, SCAN_IDENT, SCAN_NUMBER, SCAN_SLASH, SCAN_COMMENT, SCAN_STAR,
    SCAN_LESS, SCAN_GREATER, SCAN_ASSIGN, SCAN_BANG
  } scan_stage_e;

  typedef struct {
    cts_pkg::kind_e         kind;
    logic [OFFSET_BITS-1:0] start;
    logic [7:0]             length;
    logic [LINE_BITS-1:0]   line;
    logic [7:0]             bad;
    logic                   last;
  } token_t;

  scan_stage_e            stage;
  logic [LINE_BITS-1:0]   line_cnt;
  logic [OFFSET_BITS-1:0] byte_ofs;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [7:0]             tok_len;
  logic [7:0]             name_head [6];

  token_t expected_tokens [$];
  token_t step_tok [2];
  int     step_n;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("%0t ns token mismatch: %s", $time, msg);
  endtask

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic bump_line();
    if (line_cnt != '1) line_cnt++;
  endtask

  task automatic add_token(input cts_pkg::kind_e k, input logic [OFFSET_BITS-1:0] s,
                           input logic [7:0] n, input logic [7:0] b);
    step_tok[step_n] = '{kind: k, start: s, length: n, line: line_cnt, bad: b, last: 1'b0};
    step_n++;
  endtask

  // Bytes past the name length stay zero, so the packed head alone tells the
  // keyword apart; only names longer than six letters need the length check.
  function automatic cts_pkg::kind_e name_kind();
    logic [47:0] head;
    head = {name_head[0], name_head[1], name_head[2],
            name_head[3], name_head[4], name_head[5]};
    if (tok_len > 8'd6) return cts_pkg::K_ID;
    case (head)
      {"void", 16'h0}: return cts_pkg::K_VOID;
      {"int", 24'h0}:  return cts_pkg::K_INT;
      {"if", 32'h0}:   return cts_pkg::K_IF;
      {"else", 16'h0}: return cts_pkg::K_ELSE;
      {"while", 8'h0}: return cts_pkg::K_WHILE;
      "return":        return cts_pkg::K_RETURN;
      default:         return cts_pkg::K_ID;
    endcase
  endfunction

  task automatic start_token(input logic [7:0] c, input logic [OFFSET_BITS-1:0] pos);
    cts_pkg::kind_e k;
    stage = SCAN_START;
    k     = cts_pkg::K_ERR;
    if (is_letter(c)) begin
      stage     = SCAN_IDENT;
      tok_start = pos;
      tok_len   = 8'd1;
      foreach (name_head[i]) name_head[i] = 8'h00;
      name_head[0] = c;
    end else if (is_digit(c)) begin
      stage     = SCAN_NUMBER;
      tok_start = pos;
      tok_len   = 8'd1;
    end else if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      if (c == CH_NEWLINE) bump_line();
    end else begin
      case (c)
        "/":     stage = SCAN_SLASH;
        "<":     stage = SCAN_LESS;
        ">":     stage = SCAN_GREATER;
        "=":     stage = SCAN_ASSIGN;
        "!":     stage = SCAN_BANG;
        CH_END:  k = cts_pkg::K_END;
        "+":     k = cts_pkg::K_PLUS;
        "-":     k = cts_pkg::K_MINUS;
        "*":     k = cts_pkg::K_TIMES;
        ";":     k = cts_pkg::K_SEMI;
        ",":     k = cts_pkg::K_COMMA;
        "(":     k = cts_pkg::K_LPAREN;
        ")":     k = cts_pkg::K_RPAREN;
        "[":     k = cts_pkg::K_LBRACK;
        "]":     k = cts_pkg::K_RBRACK;
        "{":     k = cts_pkg::K_LBRACE;
        "}":     k = cts_pkg::K_RBRACE;
        default: k = cts_pkg::K_ERR;
      endcase
      if (stage != SCAN_START) begin
        tok_start = pos;
        tok_len   = 8'd1;
      end else if (k == cts_pkg::K_END) begin
        add_token(cts_pkg::K_END, pos, 8'd0, 8'd0);
      end else if (k == cts_pkg::K_ERR) begin
        add_token(cts_pkg::K_ERR, pos, 8'd1, c);
      end else begin
        add_token(k, pos, 8'd1, 8'd0);
      end
    end
  endtask

  // Operator that may take a trailing '='; any other byte is rescanned.
  task automatic close_pair(input logic [7:0] c, input logic [OFFSET_BITS-1:0] pos,
                            input cts_pkg::kind_e one, input cts_pkg::kind_e two);
    if (c == "=") begin
      stage = SCAN_START;
      add_token(two, tok_start, 8'd2, 8'd0);
    end else begin
      add_token(one, tok_start, 8'd1, 8'd0);
      start_token(c, pos);
    end
  endtask

  task automatic scan_byte(input logic [7:0] c);
    logic [OFFSET_BITS-1:0] pos;
    pos = byte_ofs;
    if (byte_ofs != '1) byte_ofs++;
    case (stage)
      SCAN_IDENT: begin
        if (is_letter(c)) begin
          if (tok_len < 8'd6) name_head[tok_len] = c;
          if (tok_len != 8'hFF) tok_len++;
        end else begin
          add_token(name_kind(), tok_start, tok_len, 8'd0);
          start_token(c, pos);
        end
      end
      SCAN_NUMBER: begin
        if (is_digit(c)) begin
          if (tok_len != 8'hFF) tok_len++;
        end else begin
          add_token(cts_pkg::K_NUM, tok_start, tok_len, 8'd0);
          start_token(c, pos);
        end
      end
      SCAN_SLASH: begin
        if (c == "*") begin
          stage = SCAN_COMMENT;
        end else begin
          add_token(cts_pkg::K_DIV, tok_start, 8'd1, 8'd0);
          start_token(c, pos);
        end
      end
      SCAN_COMMENT: begin
        if (c == "*") begin
          stage = SCAN_STAR;
        end else if (c == CH_NEWLINE) begin
          bump_line();
        end else if (c == CH_END) begin
          stage = SCAN_START;
          add_token(cts_pkg::K_END, pos, 8'd0, 8'd0);
        end
      end
      SCAN_STAR: begin
        if (c == "/") begin
          stage = SCAN_START;
        end else if (c == CH_END) begin
          stage = SCAN_START;
          add_token(cts_pkg::K_END, pos, 8'd0, 8'd0);
        end else if (c != "*") begin
          stage = SCAN_COMMENT;
          if (c == CH_NEWLINE) bump_line();
        end
      end
      SCAN_LESS:    close_pair(c, pos, cts_pkg::K_LT, cts_pkg::K_LE);
      SCAN_GREATER: close_pair(c, pos, cts_pkg::K_GT, cts_pkg::K_GE);
      SCAN_ASSIGN:  close_pair(c, pos, cts_pkg::K_ASN, cts_pkg::K_EQ);
      SCAN_BANG: begin
        if (c == "=") begin
          stage = SCAN_START;
          add_token(cts_pkg::K_NE, tok_start, 8'd2, 8'd0);
        end else begin
          add_token(cts_pkg::K_ERR, tok_start, 8'd1, c);
          start_token(c, pos);
        end
      end
      default: start_token(c, pos);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    token_t want;
    if (!rst_ni) begin
      stage     = SCAN_START;
      line_cnt  = LINE_BITS'(1);
      byte_ofs  = '0;
      tok_start = '0;
      tok_len   = 8'd0;
      foreach (name_head[i]) name_head[i] = 8'h00;
      expected_tokens.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("item with no expectation, kind %0d start %0d",
                                    token_kind_i, token_start_i));
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind_i !== 5'(want.kind))
            report_mismatch($sformatf("kind %0d, expected %0d (start %0d)",
                                      token_kind_i, want.kind, want.start));
          if (token_start_i !== want.start)
            report_mismatch($sformatf("start %0d, expected %0d", token_start_i, want.start));
          if (token_length_i !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d (start %0d)",
                                      token_length_i, want.length, want.start));
          if (line_number_i !== want.line)
            report_mismatch($sformatf("line %0d, expected %0d (start %0d)",
                                      line_number_i, want.line, want.start));
          if (bad_byte_i !== want.bad)
            report_mismatch($sformatf("bad byte %0d, expected %0d (start %0d)",
                                      bad_byte_i, want.bad, want.start));
          if (last_of_run_i !== want.last)
            report_mismatch($sformatf("last flag %0b, expected %0b (start %0d)",
                                      last_of_run_i, want.last, want.start));
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_n = 0;
        scan_byte(ch_i);
        if (step_n > 0) step_tok[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_tok[i]);
      end
      pending_o = expected_tokens.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the token scanner with C-minus-like source text: a short directed
// string that touches most token kinds and the error and end cases, then
// random token streams with noise bytes. Both sides idle at random, and the
// sink holds off once long enough to fill the block. The checker beside the
// block predicts and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OFFSET_BITS  = 24;
  localparam int LINE_BITS    = 20;
  localparam int STIM_BYTES   = 940;   // random part, in source bytes
  localparam int CALM_BYTES   = 150;   // tail of the run with no idling
  localparam int HOLD_CYCLES  = 120;   // long sink hold-off
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 16;    // extra wait once nothing is pending; generous margin

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             ch = 8'h00;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [4:0]             token_kind;
  logic [OFFSET_BITS-1:0] token_start;
  logic [7:0]             token_length;
  logic [LINE_BITS-1:0]   line_number;
  logic [7:0]             bad_byte;
  logic                   last_of_run;

  int fail_count;
  int pending;
  int sent_bytes = 0;
  bit idle_en = 1'b1;   // random idling on both sides
  bit hold_req = 1'b0;  // asks the sink for one long hold-off

  string      keywords [6] = '{"void", "int", "if", "else", "while", "return"};
  string      pair_ops [4] = '{"<=", ">=", "==", "!="};
  string      single_ops   = "+-*/;,()[]{}<>=";
  logic [7:0] blanks [7]   = '{8'd32, 8'd9, 8'd10, 8'd10, 8'd11, 8'd12, 8'd13};

  always #5ns clk = ~clk;

  cminus_token_scanner_unit #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .ch_i           (ch),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_o   (token_kind),
    .token_start_o  (token_start),
    .token_length_o (token_length),
    .line_number_o  (line_number),
    .bad_byte_o     (bad_byte),
    .last_of_run_o  (last_of_run)
  );

  cts_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
  ) u_token_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .ch_i           (ch),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .token_kind_i   (token_kind),
    .token_start_i  (token_start),
    .token_length_i (token_length),
    .line_number_i  (line_number),
    .bad_byte_i     (bad_byte),
    .last_of_run_i  (last_of_run),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Offer one source byte. Called right after a falling edge; returns right
  // after the falling edge that follows acceptance. Valid drops only for an
  // idle burst taken before the byte is offered, never while it waits.
  task automatic put_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid = 1'b1;
    ch       = b;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "a" : "A";
    return base + 8'($urandom_range(0, 25));
  endfunction

  // One random piece of source: mostly well-formed tokens and whitespace,
  // packed back to back at times so that the ending byte gets rescanned,
  // plus comments, end bytes, bang errors and raw noise.
  task automatic put_chunk();
    int pick;
    int n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 16) begin
      put_text(keywords[$urandom_range(0, 5)]);
    end else if (pick < 30) begin
      // short names, some one letter off a keyword length, some past six
      n = $urandom_range(1, 9);
      repeat (n) put_byte(rand_letter());
    end else if (pick < 40) begin
      n = $urandom_range(1, 5);
      repeat (n) put_byte("0" + 8'($urandom_range(0, 9)));
    end else if (pick < 52) begin
      put_byte(single_ops[$urandom_range(0, single_ops.len() - 1)]);
    end else if (pick < 60) begin
      put_text(pair_ops[$urandom_range(0, 3)]);
    end else if (pick < 66) begin
      // comment body: stars, slashes, newlines and arbitrary nonzero bytes
      put_text("/*");
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0:       put_byte("*");
          1:       put_byte(8'd10);
          2:       put_byte("/");
          default: put_byte(8'($urandom_range(1, 255)));
        endcase
      end
      if ($urandom_range(0, 3) == 0) put_byte("*");
      put_text("*/");
    end else if (pick < 82) begin
      put_byte(blanks[$urandom_range(0, 6)]);
    end else if (pick < 86) begin
      // bang followed by anything but '=' is an error, then a rescan
      put_byte("!");
      do b = 8'($urandom_range(0, 255)); while (b == "=");
      put_byte(b);
    end else if (pick < 88) begin
      put_byte(8'h00);
    end else if (pick < 90) begin
      // text ends inside a comment, with or without a pending star
      put_text("/*");
      if ($urandom_range(0, 1)) put_byte("x");
      if ($urandom_range(0, 1)) put_byte("*");
      put_byte(8'h00);
    end else begin
      put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Sink side: random ready bursts, one long hold-off on request.
  initial begin : sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        gap = $urandom_range(1, 14);
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Watchdog: any run that goes quiet for too long is broken.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int rand_base;
    bit long_done;
    long_done = 1'b0;

    // Reset held low, then released on a falling edge.
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: pair operators in both forms but '<=', every single operator, a
    // comment with a newline and doubled star, bang error with rescan, bad
    // bytes 0xFF and '@', a long number, end of text, and end
    // of text inside a comment and right after a comment star.
    put_text("return[a]>=b==c!=d<e>f=g/h,-*+;(){}");
    put_text("/*\n**/!q");
    put_byte(8'hFF);
    put_text("@9876543210 Zz\n");
    put_byte(8'h00);
    put_text("/*");
    put_byte(8'h00);
    put_text("/*x*");
    put_byte(8'h00);

    // Sink stalls for a long stretch while the source keeps offering
    // one-byte operators, each giving an item; the block must fill and
    // push back on its input.
    hold_req = 1'b1;
    repeat (40) put_byte("+");

    rand_base = sent_bytes;
    while (sent_bytes - rand_base < STIM_BYTES) begin
      idle_en = (sent_bytes - rand_base) < (STIM_BYTES - CALM_BYTES);
      // One name long enough to saturate the length field.
      if (!long_done && sent_bytes - rand_base > STIM_BYTES / 3) begin
        long_done = 1'b1;
        repeat (270) put_byte(rand_letter());
      end
      put_chunk();
    end
    // A final blank closes any pending token so its item is expected.
    idle_en = 1'b0;
    put_byte(8'd10);
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cts_pkg.sv
hdl/cts_front.sv
hdl/cts_queue.sv
hdl/cts_back.sv
hdl/cminus_token_scanner_unit.sv
tb/cts_checker.sv
tb/tb_top.sv
